// ----- src/hcw_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package hcw_pkg;

  localparam int unsigned FRAC_BITS = 16;
  localparam logic [16:0] ONE_FX    = 17'h10000;

  // divider: numerator padded to a multiple of the bits retired per stage
  localparam int unsigned NUM_W      = 36;
  localparam int unsigned DIV_BPS    = 4;
  localparam int unsigned DIV_STAGES = NUM_W / DIV_BPS;
  localparam logic [24:0] DEG360_FX  = 25'(360 << FRAC_BITS);
  localparam logic [21:0] DEG60_FX   = 22'(60 << FRAC_BITS);

  // reciprocals for constant division
  localparam logic [15:0] RECIP_360 = 16'd46603;    // floor(2^24 / 360)
  localparam logic [22:0] RECIP_60  = 23'd4473924;  // floor(2^28 / 60)

  typedef enum logic [1:0] {
    CFG_COUNT = 2'd0,
    CFG_SAT   = 2'd1,
    CFG_LIGHT = 2'd2,
    CFG_HUE   = 2'd3
  } hcw_cfg_e;

  typedef struct packed {
    logic [8:0]  deg;
    logic [15:0] frac;
  } hcw_hue_t;

  typedef struct packed {
    logic [16:0] chroma;
    logic [16:0] offset;
  } hcw_color_cfg_t;

  typedef struct packed {
    logic [16:0] red;
    logic [16:0] green;
    logic [16:0] blue;
  } hcw_rgb_t;

endpackage
`default_nettype wire

// ----- src/hcw_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none
module hcw_fifo #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             pop_i,
  output logic      [WIDTH-1:0] rdata_o,
  output logic                  empty_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wptr_q, rptr_q;
  logic [CW-1:0]    count_q;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) wptr_q <= ptr_inc(wptr_q);
      if (pop_i)  rptr_q <= ptr_inc(rptr_q);
      if (push_i && !pop_i)      count_q <= count_q + CW'(1);
      else if (!push_i && pop_i) count_q <= count_q - CW'(1);
    end
  end

  assign rdata_o = mem_q[rptr_q];
  assign empty_o = (count_q == '0);

endmodule
`default_nettype wire

// ----- src/hcw_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
module hcw_front
  import hcw_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       valid_i,
  input  wire logic [7:0] index_i,
  input  wire logic [8:0] divisor_i,
  input  wire logic [8:0] start_i,
  output logic            valid_o,
  output hcw_hue_t        hue_o
);

  logic [NUM_W-1:0] num_q [DIV_STAGES+1];
  logic [8:0]       rem_q [DIV_STAGES+1];
  logic             vld_q [DIV_STAGES+1];

  always_ff @(posedge clk_i) begin
    num_q[0] <= NUM_W'(index_i) * NUM_W'(DEG360_FX);
    rem_q[0] <= '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q[0] <= 1'b0;
    else         vld_q[0] <= valid_i;
  end

  // restoring division, DIV_BPS quotient bits per stage; num shifts into quotient
  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    logic [NUM_W-1:0] num_d;
    logic [8:0]       rem_d;

    always_comb begin
      logic [9:0] trial;
      num_d = num_q[k];
      rem_d = rem_q[k];
      for (int j = 0; j < DIV_BPS; j++) begin
        trial = {rem_d, num_d[NUM_W-1]};
        num_d = {num_d[NUM_W-2:0], 1'b0};
        if (trial >= {1'b0, divisor_i}) begin
          trial    = trial - {1'b0, divisor_i};
          num_d[0] = 1'b1;
        end
        rem_d = trial[8:0];
      end
    end

    always_ff @(posedge clk_i) begin
      num_q[k+1] <= num_d;
      rem_q[k+1] <= rem_d;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) vld_q[k+1] <= 1'b0;
      else         vld_q[k+1] <= vld_q[k];
    end
  end

  // whole degrees mod 360 by reciprocal, one correction
  logic [17:0] deg_sum;
  logic [17:0] deg_sum_q;
  logic [33:0] mprod_q;
  logic [15:0] frac_q;
  logic        mvld_q;

  assign deg_sum = 18'(start_i) + 18'(num_q[DIV_STAGES][32:16]);

  always_ff @(posedge clk_i) begin
    deg_sum_q <= deg_sum;
    mprod_q   <= 34'(deg_sum) * 34'(RECIP_360);
    frac_q    <= num_q[DIV_STAGES][15:0];
  end

  logic [9:0]  quot;
  logic [17:0] rem_deg;
  logic [17:0] rem_fix;

  assign quot    = mprod_q[33:24];
  assign rem_deg = deg_sum_q - 18'(quot) * 18'd360;
  assign rem_fix = (rem_deg >= 18'd360) ? rem_deg - 18'd360 : rem_deg;

  always_ff @(posedge clk_i) begin
    hue_o.deg  <= rem_fix[8:0];
    hue_o.frac <= frac_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mvld_q  <= 1'b0;
      valid_o <= 1'b0;
    end else begin
      mvld_q  <= vld_q[DIV_STAGES];
      valid_o <= mvld_q;
    end
  end

endmodule
`default_nettype wire

// ----- src/hcw_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
module hcw_back
  import hcw_pkg::*;
(
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           valid_i,
  input  hcw_hue_t            hue_i,
  input  hcw_color_cfg_t      cfg_i,
  output logic                valid_o,
  output hcw_rgb_t            rgb_o
);

  typedef enum logic [2:0] {
    SEC_RY = 3'd0,
    SEC_YG = 3'd1,
    SEC_GC = 3'd2,
    SEC_CB = 3'd3,
    SEC_BM = 3'd4,
    SEC_MR = 3'd5
  } sector_e;

  // stage 1: sector and triangle weight
  sector_e     sec_d;
  logic [8:0]  deg120;
  logic [22:0] rem120;
  logic [21:0] hue_dev, wgt_d;

  always_comb begin
    if      (hue_i.deg < 9'd60)  sec_d = SEC_RY;
    else if (hue_i.deg < 9'd120) sec_d = SEC_YG;
    else if (hue_i.deg < 9'd180) sec_d = SEC_GC;
    else if (hue_i.deg < 9'd240) sec_d = SEC_CB;
    else if (hue_i.deg < 9'd300) sec_d = SEC_BM;
    else                         sec_d = SEC_MR;
    if (hue_i.deg >= 9'd240)      deg120 = hue_i.deg - 9'd240;
    else if (hue_i.deg >= 9'd120) deg120 = hue_i.deg - 9'd120;
    else                          deg120 = hue_i.deg;
    rem120 = {deg120[6:0], hue_i.frac};
    if (rem120 >= 23'(DEG60_FX)) hue_dev = 22'(rem120 - 23'(DEG60_FX));
    else                         hue_dev = 22'(23'(DEG60_FX) - rem120);
    wgt_d = DEG60_FX - hue_dev;
  end

  sector_e     sec1_q, sec2_q, sec3_q, sec4_q;
  logic [21:0] wgt_q;
  logic [22:0] p_q, p3_q;
  logic [45:0] q2_q;
  logic [16:0] x_q;
  logic [3:0]  vld_q;

  logic [38:0] cw_prod;
  logic [16:0] xt;
  logic [22:0] xrem;
  logic [16:0] x_d;

  assign cw_prod = 39'(cfg_i.chroma) * 39'(wgt_q);
  assign xt      = q2_q[44:28];
  assign xrem    = p3_q - 23'(xt) * 23'd60;
  assign x_d     = (xrem >= 23'd60) ? xt + 17'd1 : xt;

  always_ff @(posedge clk_i) begin
    sec1_q <= sec_d;
    wgt_q  <= wgt_d;
    sec2_q <= sec1_q;
    p_q    <= cw_prod[38:16];
    sec3_q <= sec2_q;
    q2_q   <= 46'(p_q) * 46'(RECIP_60);
    p3_q   <= p_q;
    sec4_q <= sec3_q;
    x_q    <= x_d;
  end

  logic [16:0] r_raw, g_raw, b_raw;

  always_comb begin
    case (sec4_q)
      SEC_RY: begin r_raw = cfg_i.chroma; g_raw = x_q;          b_raw = '0; end
      SEC_YG: begin r_raw = x_q;          g_raw = cfg_i.chroma; b_raw = '0; end
      SEC_GC: begin r_raw = '0;           g_raw = cfg_i.chroma; b_raw = x_q; end
      SEC_CB: begin r_raw = '0;           g_raw = x_q;          b_raw = cfg_i.chroma; end
      SEC_BM: begin r_raw = x_q;          g_raw = '0;           b_raw = cfg_i.chroma; end
      default: begin r_raw = cfg_i.chroma; g_raw = '0;          b_raw = x_q; end
    endcase
  end

  function automatic logic [16:0] add_clamp(input logic [16:0] a, input logic [16:0] b);
    logic [17:0] s;
    s = 18'(a) + 18'(b);
    return (s > 18'(ONE_FX)) ? ONE_FX : s[16:0];
  endfunction

  always_ff @(posedge clk_i) begin
    rgb_o.red   <= add_clamp(r_raw, cfg_i.offset);
    rgb_o.green <= add_clamp(g_raw, cfg_i.offset);
    rgb_o.blue  <= add_clamp(b_raw, cfg_i.offset);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      valid_o <= 1'b0;
    end else begin
      vld_q   <= {vld_q[2:0], valid_i};
      valid_o <= vld_q[3];
    end
  end

endmodule
`default_nettype wire

// ----- src/hsl_color_wheel_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// channel   dir  handshake         payload
// input     in   push / full       color_index_i
// result    out  pop / empty       red_level_o, green_level_o, blue_level_o
// config    in   cfg_we_i          cfg_idx_i, cfg_data_i
//
// One item per cycle sustained while full stays low and the result queue is
// popped. From the accepting edge, an item passes the input register, 9
// divider stages of 4 quotient bits each, the mod 360 registers, the hue
// queue, the color back end registers and the result queue before empty falls.
// full rises when the hue queue has no credit left; the back end stops
// issuing when the result queue has no credit left. Reset empties everything.
module hsl_color_wheel_unit
  import hcw_pkg::*;
#(
  parameter int unsigned MID_DEPTH = 16,
  parameter int unsigned OUT_DEPTH = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  color_index_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [16:0]      red_level_o,
  output logic [16:0]      green_level_o,
  output logic [16:0]      blue_level_o,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [16:0] cfg_data_i
);

  localparam int unsigned MCW = $clog2(MID_DEPTH + 1);
  localparam int unsigned OCW = $clog2(OUT_DEPTH + 1);

  logic [8:0]  count_q, start_q;
  logic [16:0] sat_q, light_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 9'd1;
      sat_q   <= ONE_FX;
      light_q <= 17'h08000;
      start_q <= '0;
    end else if (cfg_we_i) begin
      case (hcw_cfg_e'(cfg_idx_i))
        CFG_COUNT: count_q <= cfg_data_i[8:0];
        CFG_SAT:   sat_q   <= cfg_data_i;
        CFG_LIGHT: light_q <= cfg_data_i;
        CFG_HUE:   start_q <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  // chroma and offset depend on config only
  logic [16:0]    sat_c, light_c, tw, chroma_d;
  logic [17:0]    l2, l_dev;
  logic [33:0]    cs_prod;
  hcw_color_cfg_t ccfg_q;

  always_comb begin
    sat_c    = (sat_q > ONE_FX) ? ONE_FX : sat_q;
    light_c  = (light_q > ONE_FX) ? ONE_FX : light_q;
    l2       = {light_c, 1'b0};
    l_dev    = (l2 >= 18'(ONE_FX)) ? l2 - 18'(ONE_FX) : 18'(ONE_FX) - l2;
    tw       = (l_dev >= 18'(ONE_FX)) ? '0 : ONE_FX - l_dev[16:0];
    cs_prod  = 34'(tw) * 34'(sat_c);
    chroma_d = cs_prod[32:16];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ccfg_q.chroma <= ONE_FX;
      ccfg_q.offset <= '0;
    end else begin
      ccfg_q.chroma <= chroma_d;
      ccfg_q.offset <= light_c - {1'b0, chroma_d[16:1]};
    end
  end

  logic [8:0] divisor;
  assign divisor = (count_q == '0) ? 9'd1 : count_q;

  // front
  logic     in_acc, front_vld;
  hcw_hue_t front_hue;
  logic [MCW-1:0] mid_used_q;

  assign full   = (mid_used_q == MCW'(MID_DEPTH));
  assign in_acc = push && !full;

  hcw_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (in_acc),
    .index_i   (color_index_i),
    .divisor_i (divisor),
    .start_i   (start_q),
    .valid_o   (front_vld),
    .hue_o     (front_hue)
  );

  logic     mid_empty, issue;
  hcw_hue_t mid_hue;
  logic [OCW-1:0] out_used_q;

  assign issue = !mid_empty && (out_used_q != OCW'(OUT_DEPTH));

  hcw_fifo #(.DEPTH(MID_DEPTH), .WIDTH($bits(hcw_hue_t))) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_vld),
    .wdata_i (front_hue),
    .pop_i   (issue),
    .rdata_o (mid_hue),
    .empty_o (mid_empty)
  );

  // back
  logic     back_vld, out_acc;
  hcw_rgb_t back_rgb, out_rgb;

  hcw_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (issue),
    .hue_i   (mid_hue),
    .cfg_i   (ccfg_q),
    .valid_o (back_vld),
    .rgb_o   (back_rgb)
  );

  assign out_acc = pop && !empty;

  hcw_fifo #(.DEPTH(OUT_DEPTH), .WIDTH($bits(hcw_rgb_t))) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (back_vld),
    .wdata_i (back_rgb),
    .pop_i   (out_acc),
    .rdata_o (out_rgb),
    .empty_o (empty)
  );

  assign red_level_o   = out_rgb.red;
  assign green_level_o = out_rgb.green;
  assign blue_level_o  = out_rgb.blue;

  // credits cover items in flight plus queued items
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_used_q <= '0;
      out_used_q <= '0;
    end else begin
      if (in_acc && !issue)      mid_used_q <= mid_used_q + MCW'(1);
      else if (!in_acc && issue) mid_used_q <= mid_used_q - MCW'(1);
      if (issue && !out_acc)      out_used_q <= out_used_q + OCW'(1);
      else if (!issue && out_acc) out_used_q <= out_used_q - OCW'(1);
    end
  end

`ifndef SYNTHESIS
  a_mid_credit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mid_used_q <= MCW'(MID_DEPTH))
    else $error("hue queue credit overrun");

  a_out_credit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_used_q <= OCW'(OUT_DEPTH))
    else $error("result queue credit overrun");

  a_no_issue_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mid_empty |-> !issue)
    else $error("back end issued from empty hue queue");

  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (red_level_o <= ONE_FX && green_level_o <= ONE_FX
                && blue_level_o <= ONE_FX))
    else $error("channel level above one");
`endif

endmodule
`default_nettype wire
